// File: rtl/core/table_key_search_engine_assert.svh
// Assertion macros used by the table key search engine back end (tkse_back).
`ifndef TABLE_KEY_SEARCH_ENGINE_ASSERT_SVH
`define TABLE_KEY_SEARCH_ENGINE_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define TKSE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tkse: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define TKSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tkse: next-cycle check failed");
`else
`define TKSE_ASSERT_SAME(label, clk, rst, ante, cons)
`define TKSE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/tkse_pkg.sv
// Types and constants shared by the table key search engine.
`timescale 1ns / 1ps
package tkse_pkg;

   // Input beat as it arrives on the request channel.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  entry_index;
      logic [31:0] data_word;
   } tkse_req_type;

   // Result beat on the response channel.
   typedef struct packed {
      logic       found;
      logic [7:0] position;
   } tkse_rsp_type;

   // Request kinds.
   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_FORWARD = 2'd1;
   localparam logic [1:0] KIND_REVERSE = 2'd2;
   localparam logic [1:0] KIND_BINARY  = 2'd3;

   // Decoded operation carried from the front end to the search engine.
   typedef enum logic [1:0] {
      OP_WRITE,
      OP_FORWARD,
      OP_REVERSE,
      OP_BINARY
   } tkse_op_type;

   typedef struct packed {
      tkse_op_type op;
      logic        in_range;
      logic [7:0]  entry_index;
      logic [31:0] data_word;
   } tkse_cmd_type;

   // Configuration register values.
   typedef struct packed {
      logic [8:0] entry_count;
      logic       signed_compare;
   } tkse_cfg_type;

   // Register map, selected by the word address bit.
   typedef enum logic [0:0] {
      CSR_ENTRY_COUNT    = 1'b0,
      CSR_SIGNED_COMPARE = 1'b1
   } tkse_csr_type;

   // Search engine states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BIN_ISSUE,
      ST_BIN_EVAL,
      ST_DONE
   } tkse_state_type;

   // Command queue between front end and engine.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// File: rtl/core/tkse_front.sv
// Front end: accepts request beats, decodes them and queues commands.
`timescale 1ns / 1ps
module tkse_front
   import tkse_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  tkse_req_type req_beat,
   output logic         cmd_valid,
   input  logic         cmd_take,
   output tkse_cmd_type cmd
);

   tkse_cmd_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff;
   logic [QPTR_W-1:0]         wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff;
   logic [QPTR_W-1:0]         rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff;
   logic [QCNT_W-1:0]         count_in;
   logic                      push;
   logic                      pop;
   tkse_cmd_type              decoded;

   // Classify the incoming beat and check a write index against the table depth.
   always_comb begin
      decoded.entry_index = req_beat.entry_index;
      decoded.data_word   = req_beat.data_word;
      decoded.in_range    = (32'(req_beat.entry_index) < TABLE_DEPTH);
      case (req_beat.kind)
         KIND_WRITE:   decoded.op = OP_WRITE;
         KIND_FORWARD: decoded.op = OP_FORWARD;
         KIND_REVERSE: decoded.op = OP_REVERSE;
         KIND_BINARY:  decoded.op = OP_BINARY;
         default:      decoded.op = OP_WRITE;
      endcase
   end

   // The queue stalls the request channel only when it is full.
   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_take && cmd_valid;
   assign cmd       = queue_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: rtl/core/tkse_back.sv
// Search engine: key memory, linear and binary search sequencer, result register.
`timescale 1ns / 1ps
`include "table_key_search_engine_assert.svh"
module tkse_back
   import tkse_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int KEY_WIDTH   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  tkse_cfg_type cfg,
   input  logic         cmd_valid,
   output logic         cmd_take,
   input  tkse_cmd_type cmd,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output tkse_rsp_type rsp_beat
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Key memory, one write port and one registered read port.
   logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [KEY_WIDTH-1:0] mem_wdata;

   tkse_state_type       state_ff;
   tkse_state_type       state_in;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic                 sgn_ff;
   logic                 sgn_in;
   logic [CNT_W-1:0]     n_ff;
   logic [CNT_W-1:0]     n_in;
   logic [IDX_W-1:0]     addr_ff;
   logic [IDX_W-1:0]     addr_in;
   logic [CNT_W-1:0]     left_ff;
   logic [CNT_W-1:0]     left_in;
   logic                 rev_ff;
   logic                 rev_in;
   logic                 rd_pend_ff;
   logic                 rd_pend_in;
   logic [IDX_W-1:0]     rd_addr_q_ff;
   logic [IDX_W-1:0]     rd_addr_q_in;
   logic [CNT_W-1:0]     lo_ff;
   logic [CNT_W-1:0]     lo_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic [CNT_W-1:0]     mid_ff;
   logic [CNT_W-1:0]     mid_in;
   logic [IDX_W-1:0]     at_ff;
   logic [IDX_W-1:0]     at_in;
   logic                 res_found_ff;
   logic                 res_found_in;
   logic [7:0]           res_pos_ff;
   logic [7:0]           res_pos_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   tkse_rsp_type         out_beat_ff;
   tkse_rsp_type         out_beat_in;

   logic [CNT_W-1:0]     n_sat;
   logic [CNT_W-1:0]     probe_mid;
   logic [CNT_W-1:0]     probe_at;
   logic [KEY_WIDTH-1:0] sign_flip;
   logic [KEY_WIDTH-1:0] ord_key;
   logic [KEY_WIDTH-1:0] ord_entry;
   logic                 key_eq;
   logic                 key_gt;
   logic                 out_free;

   // Count of entries in use, saturated at the table depth.
   assign n_sat = (32'(cfg.entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(cfg.entry_count);

   // Flipping the sign bit turns two's complement order into unsigned order.
   assign sign_flip = KEY_WIDTH'(sgn_ff) << (KEY_WIDTH - 1);
   assign ord_key   = key_ff ^ sign_flip;
   assign ord_entry = rd_data_ff ^ sign_flip;
   assign key_eq    = (ord_key == ord_entry);
   assign key_gt    = (ord_key > ord_entry);

   // Probe position of the current binary search window.
   assign probe_mid = cnt_ff >> 1;
   assign probe_at  = lo_ff + probe_mid;

   assign out_free = !out_valid_ff || !rsp_stall;

   // Sequencer: next state, memory control and search bookkeeping.
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      sgn_in       = sgn_ff;
      n_in         = n_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      rev_in       = rev_ff;
      rd_pend_in   = 1'b0;
      rd_addr_q_in = rd_addr_q_ff;
      lo_in        = lo_ff;
      cnt_in       = cnt_ff;
      mid_in       = mid_ff;
      at_in        = at_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      cmd_take     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = IDX_W'(cmd.entry_index);
      mem_wdata    = KEY_WIDTH'(cmd.data_word);
      rd_addr      = addr_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_beat_in  = out_beat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take     = 1'b1;
               key_in       = KEY_WIDTH'(cmd.data_word);
               sgn_in       = cfg.signed_compare;
               n_in         = n_sat;
               res_found_in = 1'b0;
               res_pos_in   = 8'd0;
               case (cmd.op)
                  OP_WRITE: begin
                     // A write outside the table is dropped but still answered.
                     mem_we     = cmd.in_range;
                     res_pos_in = cmd.entry_index;
                     state_in   = ST_DONE;
                  end
                  OP_FORWARD, OP_REVERSE: begin
                     rev_in   = (cmd.op == OP_REVERSE);
                     addr_in  = (cmd.op == OP_REVERSE) ? IDX_W'(n_sat - CNT_W'(1)) : '0;
                     left_in  = n_sat;
                     state_in = ST_SCAN;
                  end
                  OP_BINARY: begin
                     lo_in    = '0;
                     cnt_in   = n_sat;
                     state_in = ST_BIN_ISSUE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle and check the previous one.
            if (left_ff != '0) begin
               rd_addr      = addr_ff;
               addr_in      = rev_ff ? addr_ff - IDX_W'(1) : addr_ff + IDX_W'(1);
               left_in      = left_ff - CNT_W'(1);
               rd_pend_in   = 1'b1;
               rd_addr_q_in = addr_ff;
            end
            if (rd_pend_ff && key_eq) begin
               res_found_in = 1'b1;
               res_pos_in   = 8'(rd_addr_q_ff);
               state_in     = ST_DONE;
            end else if (!rd_pend_ff && left_ff == '0) begin
               state_in = ST_DONE;
            end
         end

         ST_BIN_ISSUE: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_addr  = IDX_W'(probe_at);
               at_in    = IDX_W'(probe_at);
               mid_in   = probe_mid;
               state_in = ST_BIN_EVAL;
            end
         end

         ST_BIN_EVAL: begin
            // Narrow the window to the half that can still hold the key.
            if (key_eq) begin
               res_found_in = 1'b1;
               res_pos_in   = 8'(at_ff);
               state_in     = ST_DONE;
            end else begin
               if (key_gt) begin
                  lo_in  = CNT_W'(at_ff) + CNT_W'(1);
                  cnt_in = cnt_ff - mid_ff - CNT_W'(1);
               end else begin
                  cnt_in = mid_ff;
               end
               state_in = ST_BIN_ISSUE;
            end
         end

         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (out_free) begin
               out_valid_in         = 1'b1;
               out_beat_in.found    = res_found_ff;
               out_beat_in.position = res_pos_ff;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Search bookkeeping and result payload.
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      sgn_ff       <= sgn_in;
      n_ff         <= n_in;
      addr_ff      <= addr_in;
      left_ff      <= left_in;
      rev_ff       <= rev_in;
      rd_addr_q_ff <= rd_addr_q_in;
      lo_ff        <= lo_in;
      cnt_ff       <= cnt_in;
      mid_ff       <= mid_in;
      at_ff        <= at_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      out_beat_ff  <= out_beat_in;
   end

   // Key memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

   // A scan only checks entries inside the active count.
   `TKSE_ASSERT_SAME(a_scan_in_count, clock, reset, (state_ff == ST_SCAN) && rd_pend_ff, CNT_W'(rd_addr_q_ff) < n_ff)
   // A binary probe is only evaluated for a non-empty window inside the count.
   `TKSE_ASSERT_SAME(a_probe_in_count, clock, reset, state_ff == ST_BIN_EVAL, (cnt_ff != '0) && (CNT_W'(at_ff) < n_ff))
   // The binary window never reaches past the active count.
   `TKSE_ASSERT_SAME(a_window_in_count, clock, reset, state_ff == ST_BIN_ISSUE, ({1'b0, lo_ff} + {1'b0, cnt_ff}) <= {1'b0, n_ff})

endmodule

// File: rtl/core/table_key_search_engine.sv
// Top level of the table key search engine: register port, front end and search engine.
// A forward or reverse search scans up to entry_count entries and stops early on a match;
// a binary search narrows its window on each probe. One item is in work at a time.
// Reset (synchronous, active high) clears the queue, the sequencer and both registers;
// the key table is not cleared and holds undefined data until written.
`timescale 1ns / 1ps
module table_key_search_engine
   import tkse_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int KEY_WIDTH   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  tkse_req_type req_beat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output tkse_rsp_type rsp_beat,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   tkse_cfg_type cfg_ff;
   tkse_cfg_type cfg_in;
   tkse_csr_type csr_sel;
   logic         csr_write;
   logic         cmd_valid;
   logic         cmd_take;
   tkse_cmd_type cmd;

   assign csr_pready = 1'b1;
   assign csr_sel    = tkse_csr_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes in the access phase.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_sel)
            CSR_ENTRY_COUNT:    cfg_in.entry_count    = csr_pwdata[8:0];
            CSR_SIGNED_COMPARE: cfg_in.signed_compare = csr_pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_sel)
         CSR_ENTRY_COUNT:    csr_prdata = 32'(cfg_ff.entry_count);
         CSR_SIGNED_COMPARE: csr_prdata = 32'(cfg_ff.signed_compare);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tkse_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd)
   );

   tkse_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule
